>>> rtl/cht_pkg.sv
package cht_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned CapW = 11;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
  } rsp_t;

  // Folded key before the bucket reduction.
  function automatic logic [63:0] hash_fold(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] x;
    x = lo ^ hi;
    return x ^ (x >> 20) ^ (x >> 12);
  endfunction

endpackage

>>> rtl/chained_hash_table_engine.sv
// Channel   | Direction | Handshake              | Payload
// req       | in        | req_valid_i/req_ready_o | cht_pkg::req_t
// rsp       | out       | rsp_valid_o/rsp_ready_i | cht_pkg::rsp_t
// cfg       | in        | cfg_we_i                | capacity (11 bits)
//
// One item at a time. After reset a clearing pass marks every bucket empty
// and fills the free queue, one entry per cycle; no item is accepted
// meanwhile. An insert goes through hash, pop, head, write and result; a find
// or a missed remove through hash, pop, head, then a node read and a compare
// per chain node visited, set by the registered read of the node memories,
// and a remove that hits one free step more. Full, empty and an unused code
// go straight from hash to result. The result waits in an output register;
// the block is ready again in the cycle after the result has been transferred.
module chained_hash_table_engine #(
  parameter int unsigned NODES   = 1024,
  parameter int unsigned BUCKETS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  cht_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output cht_pkg::rsp_t  rsp_o,
  input  logic           cfg_we_i,
  input  logic [10:0]    cfg_wdata_i
);

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SWP = (NODES > BUCKETS) ? NODES : BUCKETS;
  localparam int unsigned SW = $clog2(SWP + 1);
  localparam int unsigned QW = $clog2(NODES + 1);
  localparam int unsigned HW = NW + 1;  // head/next with valid bit on top

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_INSW   = 4'd4;
  localparam logic [3:0] S_NODE   = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_FREE   = 4'd7;
  localparam logic [3:0] S_RSP    = 4'd8;
  localparam logic [3:0] S_POP    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [SW-1:0]    sweep_q, sweep_d;
  cht_pkg::req_t    req_q, req_d;
  cht_pkg::rsp_t    rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [10:0]      cap_q, cap_d;
  logic [10:0]      cnt_q, cnt_d;
  logic [NW-1:0]    fq_head_q, fq_head_d;
  logic [QW-1:0]    fq_cnt_q, fq_cnt_d;
  logic [BW-1:0]    bkt_q, bkt_d;
  logic [HW-1:0]    cur_q, cur_d;
  logic [NW-1:0]    prev_q, prev_d;
  logic             have_prev_q, have_prev_d;
  logic [QW-1:0]    steps_q, steps_d;
  logic [NW-1:0]    newn_q, newn_d;

  // Memory ports.
  logic              hd_we;
  logic [BW-1:0]     hd_wa, hd_ra;
  logic [HW-1:0]     hd_wd, hd_rd;
  logic              nk_we;
  logic [NW-1:0]     nk_wa, nk_ra;
  logic [191:0]      nk_wd, nk_rd;
  logic              nx_we;
  logic [NW-1:0]     nx_wa, nx_ra;
  logic [HW-1:0]     nx_wd, nx_rd;
  logic              fq_we;
  logic [NW-1:0]     fq_wa, fq_ra;
  logic [NW-1:0]     fq_wd, fq_rd;

  logic [63:0]       fold;
  logic [NW-1:0]     cur_idx;
  logic [NW:0]       tail_sum;

  assign fold    = cht_pkg::hash_fold(req_q.key_low, req_q.key_high);
  assign cur_idx = cur_q[NW-1:0];
  assign tail_sum = {1'b0, fq_head_q} + (NW+1)'(fq_cnt_q);

  cht_ram #(.Width(HW), .Depth(BUCKETS)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );
  cht_ram #(.Width(192), .Depth(NODES)) u_node (
    .clk_i, .we_i(nk_we), .waddr_i(nk_wa), .wdata_i(nk_wd), .raddr_i(nk_ra), .rdata_o(nk_rd)
  );
  cht_ram #(.Width(HW), .Depth(NODES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd)
  );
  cht_ram #(.Width(NW), .Depth(NODES)) u_free (
    .clk_i, .we_i(fq_we), .waddr_i(fq_wa), .wdata_i(fq_wd), .raddr_i(fq_ra), .rdata_o(fq_rd)
  );

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Sequencer: one memory access step per cycle.
  always_comb begin
    state_d = state_q; sweep_d = sweep_q; req_d = req_q; rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q; cap_d = cap_q; cnt_d = cnt_q;
    fq_head_d = fq_head_q; fq_cnt_d = fq_cnt_q; bkt_d = bkt_q; cur_d = cur_q;
    prev_d = prev_q; have_prev_d = have_prev_q; steps_d = steps_q; newn_d = newn_q;
    hd_we = 1'b0; hd_wa = bkt_q; hd_wd = '0; hd_ra = bkt_q;
    nk_we = 1'b0; nk_wa = newn_q; nk_ra = cur_idx;
    nk_wd = {req_q.key_low, req_q.key_high, req_q.value};
    nx_we = 1'b0; nx_wa = newn_q; nx_wd = hd_rd; nx_ra = cur_idx;
    fq_we = 1'b0; fq_wa = tail_sum[NW-1:0]; fq_wd = cur_idx; fq_ra = fq_head_q;

    if (cfg_we_i) cap_d = cfg_wdata_i;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        if (sweep_q < SW'(BUCKETS)) begin
          hd_we = 1'b1; hd_wa = sweep_q[BW-1:0]; hd_wd = '0;
        end
        if (sweep_q < SW'(NODES)) begin
          fq_we = 1'b1; fq_wa = sweep_q[NW-1:0]; fq_wd = sweep_q[NW-1:0];
        end
        sweep_d = sweep_q + SW'(1);
        if (sweep_q == SW'(SWP - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d = req_i; state_d = S_HASH;
        end
      end
      S_HASH: begin
        bkt_d = BW'(fold % 64'(BUCKETS));
        rsp_d.found_value = cht_pkg::ALL_ONES;
        rsp_d.status = cht_pkg::ST_MISS;
        have_prev_d = 1'b0; steps_d = '0;
        if (req_q.operation == cht_pkg::OP_INSERT) begin
          if (cnt_q >= cap_q || fq_cnt_q == '0) begin
            rsp_d.status = cht_pkg::ST_FULL; state_d = S_RSP;
          end else begin
            state_d = S_POP;
          end
        end else if (req_q.operation == cht_pkg::OP_FIND ||
                     req_q.operation == cht_pkg::OP_REMOVE) begin
          if (cnt_q == '0) begin
            rsp_d.status = cht_pkg::ST_EMPTY; state_d = S_RSP;
          end else begin
            state_d = S_POP;
          end
        end else begin
          state_d = S_RSP;
        end
      end
      S_POP: begin
        // Head read and free queue read are in flight.
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (req_q.operation == cht_pkg::OP_INSERT) begin
          newn_d = fq_rd; state_d = S_INSW;
        end else begin
          cur_d = hd_rd;
          state_d = hd_rd[NW] ? S_NODE : S_RSP;
        end
      end
      S_INSW: begin
        nk_we = 1'b1; nk_wa = fq_rd;
        nx_we = 1'b1; nx_wa = fq_rd; nx_wd = hd_rd;
        hd_we = 1'b1; hd_wd = {1'b1, fq_rd};
        fq_head_d = (fq_head_q == NW'(NODES - 1)) ? '0 : fq_head_q + NW'(1);
        fq_cnt_d = fq_cnt_q - QW'(1);
        cnt_d = cnt_q + 11'd1;
        rsp_d.status = cht_pkg::ST_OK;
        state_d = S_RSP;
      end
      S_NODE: begin
        // Node key and next reads are in flight.
        state_d = S_CMP;
      end
      S_CMP: begin
        if (nk_rd[191:64] == {req_q.key_low, req_q.key_high}) begin
          rsp_d.status = cht_pkg::ST_OK;
          if (req_q.operation == cht_pkg::OP_FIND) begin
            rsp_d.found_value = nk_rd[63:0];
            state_d = S_RSP;
          end else begin
            if (have_prev_q) begin
              nx_we = 1'b1; nx_wa = prev_q; nx_wd = nx_rd;
            end else begin
              hd_we = 1'b1; hd_wd = nx_rd;
            end
            state_d = S_FREE;
          end
        end else begin
          prev_d = cur_idx; have_prev_d = 1'b1;
          cur_d = nx_rd; steps_d = steps_q + QW'(1);
          state_d = (nx_rd[NW] && steps_q < QW'(NODES - 1)) ? S_NODE : S_RSP;
        end
      end
      S_FREE: begin
        nx_we = 1'b1; nx_wa = cur_idx; nx_wd = '0;
        if (fq_cnt_q < QW'(NODES)) begin
          fq_we = 1'b1;
          fq_wa = (tail_sum >= (NW+1)'(NODES)) ? NW'(tail_sum - (NW+1)'(NODES))
                                               : tail_sum[NW-1:0];
          fq_cnt_d = fq_cnt_q + QW'(1);
        end
        cnt_d = cnt_q - 11'd1;
        state_d = S_RSP;
      end
      S_RSP: begin
        rsp_valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; sweep_q <= '0; rsp_valid_q <= 1'b0;
      cap_q <= 11'd1024; cnt_q <= '0; fq_head_q <= '0; fq_cnt_q <= QW'(NODES);
    end else begin
      state_q <= state_d; sweep_q <= sweep_d; rsp_valid_q <= rsp_valid_d;
      cap_q <= cap_d; cnt_q <= cnt_d; fq_head_q <= fq_head_d; fq_cnt_q <= fq_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d; bkt_q <= bkt_d; cur_q <= cur_d;
    prev_q <= prev_d; have_prev_q <= have_prev_d; steps_q <= steps_d; newn_q <= newn_d;
  end

endmodule

>>> rtl/cht_ram.sv
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/cht_checker.sv
module cht_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input cht_pkg::rsp_t rsp_o
);

  // A result held back by the sink keeps its value.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  // The block never takes an item while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("ready while a result is pending");

  // An accepted item produces no result in the very next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !rsp_valid_o && !req_ready_o)
    else $error("item finished too early");

  // A found value is reported only with status ok.
  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != cht_pkg::ST_OK |->
      rsp_o.found_value == cht_pkg::ALL_ONES)
    else $error("value on a failed operation");

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);

>>> tb/tb.sv
module tb;

  localparam int unsigned NumNodes   = 1024;
  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned SettleCyc  = 20;
  localparam int unsigned NumRemoved = 350;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic [127:0] key;
    logic [63:0]  val;
  } entry_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          req_valid_i = 1'b0;
  logic          req_ready_o;
  cht_pkg::req_t req_i = '0;
  logic          rsp_valid_o;
  logic          rsp_ready_i = 1'b0;
  cht_pkg::rsp_t rsp_o;
  logic          cfg_we_i = 1'b0;
  logic [10:0]   cfg_wdata_i = '0;

  // Shadow table: each bucket keeps its entries newest first.
  entry_t        bucket_chain[NumBuckets][$];
  int unsigned   stored_count = 0;
  int unsigned   capacity_limit = 1024;
  cht_pkg::rsp_t expected_rsp_q[$];
  int unsigned   fail_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   rsp_hold_cycles = 0;
  int unsigned   idle_cycles = 0;
  logic [63:0]   pool_fold[16];

  chained_hash_table_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Bucket index of a key, folded and reduced to the table size.
  function automatic int unsigned bucket_index(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] x;
    logic [63:0] h;
    x = lo ^ hi;
    h = x ^ (x >> 20) ^ (x >> 12);
    return int'(h % NumBuckets);
  endfunction

  // Work out the result of one accepted request and update the shadow table.
  task automatic predict_lookup(input cht_pkg::req_t r);
    int unsigned   b;
    cht_pkg::rsp_t res;
    int            hit;
    b = bucket_index(r.key_low, r.key_high);
    res.status = cht_pkg::ST_MISS;
    res.found_value = cht_pkg::ALL_ONES;
    hit = -1;
    if (r.operation == cht_pkg::OP_INSERT) begin
      if (stored_count >= capacity_limit || stored_count >= NumNodes) begin
        res.status = cht_pkg::ST_FULL;
      end else begin
        bucket_chain[b].push_front({r.key_high, r.key_low, r.value});
        stored_count++;
        res.status = cht_pkg::ST_OK;
      end
    end else if (r.operation == cht_pkg::OP_FIND || r.operation == cht_pkg::OP_REMOVE) begin
      if (stored_count == 0) begin
        res.status = cht_pkg::ST_EMPTY;
      end else begin
        foreach (bucket_chain[b][i]) begin
          if (hit < 0 && bucket_chain[b][i].key == {r.key_high, r.key_low}) hit = i;
        end
        if (hit >= 0) begin
          res.status = cht_pkg::ST_OK;
          if (r.operation == cht_pkg::OP_FIND) begin
            res.found_value = bucket_chain[b][hit].val;
          end else begin
            bucket_chain[b].delete(hit);
            stored_count--;
          end
        end
      end
    end
    expected_rsp_q.push_back(res);
  endtask

  // Offer one request in bursts with random gaps, and wait for its transfer.
  task automatic send_request(input logic [1:0] op, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [63:0] val);
    cht_pkg::req_t r;
    int unsigned   gap;
    r.operation = op;
    r.key_low = lo;
    r.key_high = hi;
    r.value = val;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    predict_lookup(r);
  endtask

  // Stop offering and wait until every outstanding result has arrived.
  task automatic drain_results();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [10:0] cap);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    capacity_limit = cap;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Find and remove on an empty table, and the unused operation code.
  task automatic test_empty_table();
    send_request(cht_pkg::OP_FIND, '0, '0, rand64());
    send_request(cht_pkg::OP_REMOVE, cht_pkg::ALL_ONES, cht_pkg::ALL_ONES, rand64());
    send_request(OpUnused, rand64(), rand64(), rand64());
  endtask

  // Extreme keys and values, duplicates, and collisions within one bucket.
  task automatic test_extremes();
    logic [63:0] x;
    x = rand64();
    send_request(cht_pkg::OP_INSERT, '0, '0, '0);
    send_request(cht_pkg::OP_INSERT, cht_pkg::ALL_ONES, cht_pkg::ALL_ONES, cht_pkg::ALL_ONES);
    send_request(cht_pkg::OP_FIND, '0, '0, '0);
    send_request(cht_pkg::OP_FIND, cht_pkg::ALL_ONES, cht_pkg::ALL_ONES, '0);
    send_request(cht_pkg::OP_INSERT, '0, '0, 64'h5A5A_A5A5_0F0F_F0F0);
    send_request(cht_pkg::OP_FIND, '0, '0, '0);
    send_request(cht_pkg::OP_REMOVE, '0, '0, '0);
    send_request(cht_pkg::OP_FIND, '0, '0, '0);
    // Same folded key, hence same bucket, but different keys.
    send_request(cht_pkg::OP_INSERT, x, '0, 64'd1);
    send_request(cht_pkg::OP_INSERT, '0, x, 64'd2);
    send_request(cht_pkg::OP_INSERT, ~x, cht_pkg::ALL_ONES, 64'd3);
    send_request(cht_pkg::OP_FIND, x, '0, '0);
    send_request(cht_pkg::OP_REMOVE, '0, x, '0);
    send_request(cht_pkg::OP_FIND, '0, x, '0);
    send_request(cht_pkg::OP_FIND, ~x, cht_pkg::ALL_ONES, '0);
    send_request(cht_pkg::OP_REMOVE, x ^ 64'd1, 64'd1 ^ 64'd1, '0);
    send_request(OpUnused, '0, '0, '0);
    send_request(cht_pkg::OP_REMOVE, cht_pkg::ALL_ONES, cht_pkg::ALL_ONES, '0);
  endtask

  // Zero capacity, and capacity lowered below the stored count.
  task automatic test_capacity_limits();
    set_capacity(11'd0);
    send_request(cht_pkg::OP_INSERT, rand64(), rand64(), rand64());
    set_capacity(11'd1);
    send_request(cht_pkg::OP_INSERT, rand64(), rand64(), rand64());
    send_request(cht_pkg::OP_FIND, rand64(), rand64(), rand64());
    set_capacity(11'd5);
    send_request(cht_pkg::OP_INSERT, 64'd7, 64'd9, rand64());
    send_request(cht_pkg::OP_INSERT, 64'd7, 64'd9, rand64());
    send_request(cht_pkg::OP_INSERT, 64'd8, 64'd9, rand64());
  endtask

  // Fill the node pool with capacity above it, then free part of it again.
  task automatic test_pool_exhaustion();
    set_capacity(11'd2047);
    for (int i = 0; i <= int'(NumNodes); i++) begin
      send_request(cht_pkg::OP_INSERT, 64'(i), ~64'(i), rand64());
    end
    set_capacity(11'd1024);
    send_request(cht_pkg::OP_INSERT, rand64(), rand64(), rand64());
    set_capacity(11'd10);
    send_request(cht_pkg::OP_INSERT, rand64(), rand64(), rand64());
    for (int i = int'(NumNodes); i > int'(NumNodes) - int'(NumRemoved); i--) begin
      send_request(cht_pkg::OP_REMOVE, 64'(i), ~64'(i), '0);
    end
  endtask

  // Random traffic over a small key pool so finds and removes mostly hit.
  task automatic test_random_traffic(input int unsigned n_items, input logic [10:0] cap,
                                     input bit with_hold);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0]  op;
    int unsigned pick;
    set_capacity(cap);
    if (with_hold) rsp_hold_cycles = 400;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 42) ? cht_pkg::OP_INSERT : (pick < 70) ? cht_pkg::OP_FIND :
           (pick < 95) ? cht_pkg::OP_REMOVE : OpUnused;
      if ($urandom_range(0, 9) == 0) begin
        lo = rand64();
        hi = rand64();
      end else begin
        hi = {60'h0, 4'($urandom_range(0, 2))} * 64'h9E37_79B9_7F4A_7C15;
        lo = pool_fold[$urandom_range(0, 15)] ^ hi;
      end
      send_request(op, lo, hi, rand64());
    end
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, rsp_o.status,
                 rsp_o.found_value);
        fail_count++;
      end else begin
        if (rsp_o.status !== expected_rsp_q[0].status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                   expected_rsp_q[0].status, rsp_o.status);
          fail_count++;
        end
        if (rsp_o.found_value !== expected_rsp_q[0].found_value) begin
          $display("%0t: found_value mismatch expected=%h actual=%h", $time,
                   expected_rsp_q[0].found_value, rsp_o.found_value);
          fail_count++;
        end
        void'(expected_rsp_q.pop_front());
      end
    end
  end

  // Receiver stalls: a changing pattern, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (rsp_hold_cycles > 0) begin
      rsp_ready_i <= 1'b0;
      rsp_hold_cycles--;
    end else begin
      case (($time / 640) % 3)
        0: begin
          rsp_ready_i <= 1'b1;
        end
        1: begin
          rsp_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) pool_fold[i] = rand64();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_extremes();
    test_capacity_limits();
    test_pool_exhaustion();
    test_random_traffic(120, 11'd1024, 1'b1);
    test_random_traffic(50, 11'd7, 1'b0);
    test_random_traffic(100, 11'd2047, 1'b1);
    test_random_traffic(30, 11'd40, 1'b0);
    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
